>>> hdl/bat_pkg.sv
package bat_pkg;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam logic [8:0] MAX_ENTRIES_RESET = 9'd256;

	typedef struct packed {
		logic [31:0] block_offset;
		logic [31:0] block_count;
		logic        is_read;
		logic        is_write;
	} cmd_t;

	typedef struct packed {
		logic        hit;
		logic        evicted;
		logic [31:0] read_total;
		logic [31:0] write_total;
		logic [1:0]  last_kind;
		logic [31:0] peak_count;
		logic [8:0]  entries_used;
	} res_t;

	typedef struct packed {
		logic [31:0] offset;
		logic [31:0] length;
		logic [31:0] reads;
		logic [31:0] writes;
		logic [1:0]  kind;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_HIT,
		ST_PEAK,
		ST_MISS
	} state_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage

>>> hdl/bat_ram.sv
module bat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/bat_cmp.sv
module bat_cmp import bat_pkg::*; (
	input  logic   vld,
	input  cmd_t   key,
	input  entry_t entry,
	output logic   match
);

	// An entry matches only when both the offset and the block count agree.
	assign match = vld && (entry.offset == key.block_offset) &&
		(entry.length == key.block_count);

endmodule

>>> hdl/block_access_tracker_table.sv
// Block access tracker table. An item is taken when start is high and busy is low; its result
// appears on result for exactly one cycle with done high, and the receiver cannot stall it, so
// it must capture the result in that cycle. The table lives in one single-port-read memory that
// is scanned from the oldest entry, one entry per cycle, and the scan ends early when a hit is found.
// The table needs no clearing pass after reset, and the max_entries register may be written on
// cfg_data whenever the block is idle.
module block_access_tracker_table import bat_pkg::*; #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cmd_t       cmd,
	output logic       done,
	output res_t       result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [8:0] cfg_data
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int UW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = (UW > 9) ? UW : 9;
	localparam int SW = IW + 1;
	localparam logic [LW-1:0] DEPTH_L  = LW'(TABLE_DEPTH);
	localparam logic [SW-1:0] DEPTH_S  = SW'(TABLE_DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

	state_t state_q, state_d;

	logic [8:0]    max_q;
	logic [IW-1:0] oldest_q;
	logic [UW-1:0] used_q;
	logic [31:0]   peak_q;
	logic [UW-1:0] age_q;
	logic [IW-1:0] ptr_q;
	logic          rd_v_s1;
	logic [IW-1:0] slot_s1;
	logic [IW-1:0] slot_q;
	cmd_t          cmd_q;
	entry_t        entry_q;
	logic          done_q;
	res_t          res_q;

	logic          issue;
	logic          match;
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	entry_t        ram_wdata;
	entry_t        ram_rdata;
	logic [ENTRY_W-1:0] ram_rdata_raw;

	entry_t        upd_entry;
	entry_t        new_entry;
	logic [31:0]   big;
	logic [31:0]   peak_n;
	logic [LW-1:0] limit;
	logic [LW-1:0] used_l;
	logic          evict;
	logic [SW-1:0] slot_sum;
	logic [IW-1:0] new_slot;
	logic [IW-1:0] oldest_inc;
	logic [IW-1:0] ptr_inc;
	logic [UW-1:0] used_n;
	logic [LW-1:0] used_n_l;

	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;
	assign ram_rdata = entry_t'(ram_rdata_raw);

	bat_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q),
		.rdata (ram_rdata_raw)
	);

	bat_cmp u_cmp (
		.vld   (rd_v_s1),
		.key   (cmd_q),
		.entry (ram_rdata),
		.match (match)
	);

	assign issue      = (age_q != used_q);
	assign ptr_inc    = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
	assign oldest_inc = (oldest_q == LAST_IDX) ? '0 : oldest_q + 1'b1;

	// The limit is the register value clipped to the table depth.
	assign used_l = LW'(used_q);
	assign limit  = (LW'(max_q) > DEPTH_L) ? DEPTH_L : LW'(max_q);
	assign evict  = (used_l >= limit) && (used_q != '0);

	// The new entry lands one past the newest, which is the oldest slot when the table is full.
	assign slot_sum = SW'(oldest_q) + SW'(used_q);
	assign new_slot = (slot_sum >= DEPTH_S) ? IW'(slot_sum - DEPTH_S) : IW'(slot_sum);
	assign used_n   = evict ? used_q : used_q + 1'b1;
	assign used_n_l = LW'(used_n);

	always_comb begin
		upd_entry = entry_q;
		if (cmd_q.is_read) begin
			upd_entry.reads = sat_inc(entry_q.reads);
			upd_entry.kind  = KIND_READ;
		end else if (cmd_q.is_write) begin
			upd_entry.writes = sat_inc(entry_q.writes);
			upd_entry.kind   = KIND_WRITE;
		end
	end

	always_comb begin
		new_entry.offset = cmd_q.block_offset;
		new_entry.length = cmd_q.block_count;
		new_entry.reads  = {31'd0, cmd_q.is_read};
		new_entry.writes = {31'd0, !cmd_q.is_read && cmd_q.is_write};
		new_entry.kind   = cmd_q.is_read ? KIND_READ :
			(cmd_q.is_write ? KIND_WRITE : KIND_NONE);
	end

	assign big    = (entry_q.reads > entry_q.writes) ? entry_q.reads : entry_q.writes;
	assign peak_n = (big > peak_q) ? big : peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = upd_entry;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (match) begin
					state_d = ST_HIT;
				end else if (!issue) begin
					state_d = ST_MISS;
				end
			end
			ST_HIT: begin
				ram_we  = 1'b1;
				state_d = ST_PEAK;
			end
			ST_PEAK: begin
				state_d = ST_IDLE;
			end
			ST_MISS: begin
				ram_we    = 1'b1;
				ram_waddr = new_slot;
				ram_wdata = new_entry;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= MAX_ENTRIES_RESET;
			oldest_q <= '0;
			used_q   <= '0;
			peak_q   <= '0;
			age_q    <= '0;
			ptr_q    <= '0;
			rd_v_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					age_q   <= '0;
					ptr_q   <= oldest_q;
					rd_v_s1 <= 1'b0;
				end
				ST_SEARCH: begin
					rd_v_s1 <= issue && !match;
					if (issue) begin
						age_q <= age_q + 1'b1;
						ptr_q <= ptr_inc;
					end
				end
				ST_PEAK: begin
					peak_q <= peak_n;
					done_q <= 1'b1;
				end
				ST_MISS: begin
					if (evict) begin
						oldest_q <= oldest_inc;
					end
					used_q <= used_n;
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q <= cmd;
			end
			ST_SEARCH: begin
				slot_s1 <= ptr_q;
				if (match) begin
					entry_q <= ram_rdata;
					slot_q  <= slot_s1;
				end
			end
			ST_HIT: begin
				entry_q <= upd_entry;
			end
			ST_PEAK: begin
				res_q.hit          <= 1'b1;
				res_q.evicted      <= 1'b0;
				res_q.read_total   <= entry_q.reads;
				res_q.write_total  <= entry_q.writes;
				res_q.last_kind    <= entry_q.kind;
				res_q.peak_count   <= peak_n;
				res_q.entries_used <= used_l[8:0];
			end
			ST_MISS: begin
				res_q.hit          <= 1'b0;
				res_q.evicted      <= evict;
				res_q.read_total   <= new_entry.reads;
				res_q.write_total  <= new_entry.writes;
				res_q.last_kind    <= new_entry.kind;
				res_q.peak_count   <= peak_q;
				res_q.entries_used <= used_n_l[8:0];
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hdl/bat_chk.sv
module bat_chk import bat_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input res_t result
);

	// A result strobe comes only at the end of the work on an item.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe without a preceding busy cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the block busy");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hit) |-> !result.evicted &&
			(result.peak_count >= result.read_total) &&
			(result.peak_count >= result.write_total))
		else $error("hit result inconsistent with eviction or peak");

	// A fresh entry holds at most one count, of the access kind.
	a_miss_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.read_total + result.write_total <= 32'd1))
		else $error("new entry with unexpected counters");

endmodule

bind block_access_tracker_table bat_chk u_bat_chk (.*);
